/* hw/rtl/m3inv_pkg.sv */
// Package for the 3x3 fixed-point matrix unit.
// Holds operation codes, status codes and default parameter values.
package m3inv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        CMD_INVERSE   = 2'd0,
        CMD_DETERM    = 2'd1,
        CMD_TRACE     = 2'd2,
        CMD_TRANSPOSE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

endpackage

/* hw/rtl/matrix3x3_inverse_unit_core.sv */
// 3x3 fixed-point matrix unit, top level: inverse, determinant, trace, transpose.
// Depends on m3inv_pkg and m3inv_div.
//
// The unit takes one matrix transaction per clock cycle and returns one result
// transaction for each, in order. Every operation runs through the same pipeline:
// six front stages (input, products, cofactors, partial products, determinant,
// divider operands), then 2*DATA_WIDTH + 2*FRAC_BITS + 2 divider stages that yield
// one quotient bit each, then the output register. Nine dividers run side by side,
// one per inverse entry.
// Stall on the output freezes the whole pipeline, and the input stall follows it.
module matrix3x3_inverse_unit_core #(
    parameter int DATA_WIDTH = m3inv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic signed [DATA_WIDTH-1:0] a00,
    input  logic signed [DATA_WIDTH-1:0] a01,
    input  logic signed [DATA_WIDTH-1:0] a02,
    input  logic signed [DATA_WIDTH-1:0] a10,
    input  logic signed [DATA_WIDTH-1:0] a11,
    input  logic signed [DATA_WIDTH-1:0] a12,
    input  logic signed [DATA_WIDTH-1:0] a20,
    input  logic signed [DATA_WIDTH-1:0] a21,
    input  logic signed [DATA_WIDTH-1:0] a22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] r00,
    output logic signed [DATA_WIDTH-1:0] r01,
    output logic signed [DATA_WIDTH-1:0] r02,
    output logic signed [DATA_WIDTH-1:0] r10,
    output logic signed [DATA_WIDTH-1:0] r11,
    output logic signed [DATA_WIDTH-1:0] r12,
    output logic signed [DATA_WIDTH-1:0] r20,
    output logic signed [DATA_WIDTH-1:0] r21,
    output logic signed [DATA_WIDTH-1:0] r22,
    output logic signed [DATA_WIDTH-1:0] scalar_out,
    output logic [1:0]                   status
);
    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;          // product of two entries
    localparam int CW  = 2 * W + 1;      // cofactor
    localparam int TW3 = 3 * W + 1;      // entry times cofactor
    localparam int DTW = 3 * W + 3;      // determinant
    localparam int NUW = CW + 2 * F + 1; // magnitude of 2*num
    localparam int DVW = DTW + 1;        // 2*|det|
    localparam int QW  = NUW;            // quotient width
    localparam int HW  = W / 2;          // multiplier split
    localparam int LW  = W - HW;

    typedef logic signed [W-1:0] ent_t;

    // Pipeline advances when the output stage is free.
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Stage 1: register inputs.
    logic       v1_reg;
    logic [1:0] c1_reg;
    ent_t       m1_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= cmd;
            m1_reg[0] <= a00; m1_reg[1] <= a01; m1_reg[2] <= a02;
            m1_reg[3] <= a10; m1_reg[4] <= a11; m1_reg[5] <= a12;
            m1_reg[6] <= a20; m1_reg[7] <= a21; m1_reg[8] <= a22;
        end
    end

    // Stage 2: eighteen products for the cyclic 2x2 minors.
    logic       v2_reg;
    logic [1:0] c2_reg;
    ent_t       m2_reg [9];
    logic signed [PW-1:0] pa_reg [9];
    logic signed [PW-1:0] pb_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_minor
        localparam int I  = k / 3;
        localparam int J  = k % 3;
        localparam int I1 = (I + 1) % 3;
        localparam int I2 = (I + 2) % 3;
        localparam int J1 = (J + 1) % 3;
        localparam int J2 = (J + 2) % 3;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[k] <= PW'(m1_reg[I1*3+J1]) * PW'(m1_reg[I2*3+J2]);
                pb_reg[k] <= PW'(m1_reg[I1*3+J2]) * PW'(m1_reg[I2*3+J1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg <= c1_reg;
            m2_reg <= m1_reg;
        end
    end

    // Stage 3: cofactors.
    logic       v3_reg;
    logic [1:0] c3_reg;
    ent_t       m3_reg [9];
    logic signed [CW-1:0] cf3_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg <= c2_reg;
            m3_reg <= m2_reg;
            for (int k = 0; k < 9; k++)
            begin
                cf3_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
            end
        end
    end

    // Stage 4: first-row entries times cofactors, split into two partial
    // products each (low half unsigned, high half signed).
    logic       v4_reg;
    logic [1:0] c4_reg;
    ent_t       m4_reg [9];
    logic signed [CW-1:0]    cf4_reg [9];
    logic signed [CW+LW:0]   pl4_reg [3];
    logic signed [CW+HW-1:0] ph4_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg  <= c3_reg;
            m4_reg  <= m3_reg;
            cf4_reg <= cf3_reg;
            for (int k = 0; k < 3; k++)
            begin
                pl4_reg[k] <= (CW+LW+1)'(cf3_reg[k])
                    * $signed({1'b0, m3_reg[k][LW-1:0]});
                ph4_reg[k] <= (CW+HW)'(cf3_reg[k])
                    * (CW+HW)'($signed(m3_reg[k][W-1:LW]));
            end
        end
    end

    // Stage 5: determinant.
    logic       v5_reg;
    logic [1:0] c5_reg;
    ent_t       m5_reg [9];
    logic signed [CW-1:0]  cf5_reg [9];
    logic signed [DTW-1:0] det5_reg;
    logic signed [DTW-1:0] term [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            term[k] = DTW'(pl4_reg[k]) + (DTW'(ph4_reg[k]) <<< LW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c5_reg   <= c4_reg;
            m5_reg   <= m4_reg;
            cf5_reg  <= cf4_reg;
            det5_reg <= term[0] + term[1] + term[2];
        end
    end

    // Stage 6: divider operands and scalar results.
    localparam int SW = DTW + 1;
    logic signed [SW-1:0] det_rnd;
    logic [DTW-1:0]       det_abs;
    logic [DTW-1:0]       det_mag;
    logic signed [W+1:0]  trace_sum;

    always_comb
    begin
        det_abs   = det5_reg[DTW-1] ? DTW'(-det5_reg) : DTW'(det5_reg);
        det_mag   = (det_abs + (DTW'(1) << (2 * F - 1))) >> (2 * F);
        det_rnd   = det5_reg[DTW-1] ? -$signed({1'b0, det_mag}) : $signed({1'b0, det_mag});
        trace_sum = (W+2)'(m5_reg[0]) + (W+2)'(m5_reg[4]) + (W+2)'(m5_reg[8]);
    end

    function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] maxv;
        logic signed [SW-1:0] minv;
        begin
            maxv = SW'({1'b0, {(W-1){1'b1}}});
            minv = -maxv - SW'(1);
            if (v > maxv)
            begin
                sat_fn = {1'b1, 1'b0, {(W-1){1'b1}}};
            end
            else if (v < minv)
            begin
                sat_fn = {1'b1, 1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                sat_fn = {1'b0, v[W-1:0]};
            end
        end
    endfunction

    // Tag that rides through the divider: cmd, sign per entry, zero flag, scalar with its saturation bit, transpose.
    localparam int TGW = 2 + 9 + 1 + W + 1 + W * 9;
    logic [TGW-1:0] tag6;
    logic [W:0]     scal_s;
    logic [8:0]     sgn6;
    logic [NUW-1:0] num6 [9];
    logic [DVW-1:0] den6;
    logic           zero6;

    always_comb
    begin
        zero6 = (det5_reg == '0);
        den6  = {det_abs, 1'b0};
        case (c5_reg)
            m3inv_pkg::CMD_DETERM: scal_s = sat_fn(det_rnd);
            m3inv_pkg::CMD_TRACE:  scal_s = sat_fn(SW'(trace_sum));
            default:               scal_s = '0;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic [CW-1:0] ca;
                ca = cf5_reg[j*3+i][CW-1] ? CW'(-cf5_reg[j*3+i]) : CW'(cf5_reg[j*3+i]);
                sgn6[i*3+j] = (cf5_reg[j*3+i][CW-1] != det5_reg[DTW-1])
                    && (cf5_reg[j*3+i] != '0);
                num6[i*3+j] = ({NUW'(ca)} << (2 * F + 1)) + NUW'(det_abs);
            end
        end
        tag6 = {c5_reg, sgn6, zero6, scal_s, m5_reg[0], m5_reg[3], m5_reg[6],
                m5_reg[1], m5_reg[4], m5_reg[7], m5_reg[2], m5_reg[5], m5_reg[8]};
    end

    // Operands are registered before they enter the dividers.
    logic           v6_reg;
    logic [TGW-1:0] tag6_reg;
    logic [NUW-1:0] num6_reg [9];
    logic [DVW-1:0] den6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag6_reg <= tag6;
            num6_reg <= num6;
            den6_reg <= den6;
        end
    end

    // Nine dividers; all carry the tag, but only the first one's tag and valid are used.
    logic [8:0]    dv;
    logic [QW-1:0] dq [9];
    logic [TGW-1:0] dtag [9];

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        m3inv_div #(
            .NW (NUW),
            .DW (DVW),
            .QW (QW),
            .TW (TGW)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v6_reg),
            .num       (num6_reg[k]),
            .den       (den6_reg),
            .tag       (tag6_reg),
            .out_valid (dv[k]),
            .quo       (dq[k]),
            .out_tag   (dtag[k])
        );
    end

    // Final stage: sign, saturate and select by operation.
    logic [1:0]   tc;
    logic [8:0]   ts;
    logic         tz;
    logic [W:0]   tscal;
    logic [W*9-1:0] ttr;
    logic [W:0]   qs [9];
    logic         any_sat;
    ent_t         rv [9];
    ent_t         sv;
    logic [1:0]   stv;

    assign {tc, ts, tz, tscal, ttr} = dtag[0];

    always_comb
    begin
        any_sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            logic signed [SW-1:0] q;
            q = (dq[k] > QW'({1'b0, {(SW-1){1'b1}}})) ? SW'({1'b0, {(SW-1){1'b1}}})
                : SW'(dq[k]);
            qs[k]   = sat_fn(ts[k] ? -q : q);
            any_sat = any_sat | qs[k][W];
        end
        sv  = '0;
        stv = m3inv_pkg::ST_OK;
        for (int k = 0; k < 9; k++)
        begin
            rv[k] = '0;
        end
        case (tc)
            m3inv_pkg::CMD_INVERSE:
            begin
                if (tz)
                begin
                    stv = m3inv_pkg::ST_SINGULAR;
                end
                else
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        rv[k] = qs[k][W-1:0];
                    end
                    stv = any_sat ? m3inv_pkg::ST_SATURATED : m3inv_pkg::ST_OK;
                end
            end
            m3inv_pkg::CMD_TRANSPOSE:
            begin
                for (int k = 0; k < 9; k++)
                begin
                    rv[k] = ttr[W*(8-k) +: W];
                end
            end
            default:
            begin
                sv  = tscal[W-1:0];
                stv = tscal[W] ? m3inv_pkg::ST_SATURATED : m3inv_pkg::ST_OK;
            end
        endcase
    end

    logic out_valid_reg;
    ent_t r_reg [9];
    ent_t scalar_reg;
    logic [1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= rv;
            scalar_reg <= sv;
            status_reg <= stv;
        end
    end

    assign out_valid  = out_valid_reg;
    assign r00 = r_reg[0]; assign r01 = r_reg[1]; assign r02 = r_reg[2];
    assign r10 = r_reg[3]; assign r11 = r_reg[4]; assign r12 = r_reg[5];
    assign r20 = r_reg[6]; assign r21 = r_reg[7]; assign r22 = r_reg[8];
    assign scalar_out = scalar_reg;
    assign status     = status_reg;
endmodule

/* hw/rtl/m3inv_div.sv */
// Pipelined restoring divider for the 3x3 matrix unit: one quotient bit per stage.
// Depends on nothing but its parameters.
module m3inv_div #(
    parameter int NW = 64,
    parameter int DW = 64,
    parameter int QW = 64,
    parameter int TW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] out_tag
);
    // Stage s computes quotient bit QW-1-s.
    logic [QW:0]       v_reg;
    logic [NW-1:0]     n_reg [QW+1];
    logic [DW-1:0]     d_reg [QW+1];
    logic [DW:0]       r_reg [QW+1];
    logic [QW-1:0]     q_reg [QW+1];
    logic [TW-1:0]     t_reg [QW+1];

    always_comb
    begin
        v_reg[0] = in_valid;
        n_reg[0] = num;
        d_reg[0] = den;
        r_reg[0] = '0;
        q_reg[0] = '0;
        t_reg[0] = tag;
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW+1:0] trial;
        logic [DW+1:0] rem_sh;
        logic          nbit;
        logic [QW-1:0] q_bit;
        localparam int BIT = QW - 1 - s;
        assign nbit   = (BIT < NW) ? n_reg[s][(BIT < NW) ? BIT : 0] : 1'b0;
        assign rem_sh = {r_reg[s], nbit};
        assign trial  = rem_sh - {2'b00, d_reg[s]};
        assign q_bit  = QW'(!trial[DW+1]) << BIT;

        // Valid bits follow the data and clear on reset.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s];
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
                q_reg[s+1] <= q_reg[s] | q_bit;
                if (!trial[DW+1])
                begin
                    r_reg[s+1] <= trial[DW:0];
                end
                else
                begin
                    r_reg[s+1] <= rem_sh[DW:0];
                end
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];
    assign out_tag   = t_reg[QW];
endmodule

/* hw/rtl/m3inv_checker.sv */
// Port-level checker for the 3x3 matrix unit, bound to the top level.
// Depends on m3inv_pkg for codes and the default data width.
module m3inv_checker #(
    parameter int W = m3inv_pkg::DATA_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_stall,
    input logic         in_stall,
    input logic [1:0]   status,
    input logic [W-1:0] scalar_out,
    input logic [W-1:0] r00
);
    // A waiting result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(r00))
        else $error("stalled result changed");

    // Input stall only when an output transaction waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");

    // A valid result's status never takes the unused code.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    // A singular result carries a zero matrix and no scalar.
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == m3inv_pkg::ST_SINGULAR |-> r00 == '0 && scalar_out == '0)
        else $error("singular result not zero");
endmodule

bind matrix3x3_inverse_unit_core m3inv_checker #(.W(DATA_WIDTH)) u_m3inv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .status     (status),
    .scalar_out (scalar_out),
    .r00        (r00)
);
